// ===== rtl/core/wpsa_pkg.sv =====
// Shared types and constants of the wheel pulse speed averager.
package wpsa_pkg;

	// Fixed widths
	localparam int TS_W    = 48;
	localparam int DIV_W   = 32;
	localparam int SPEED_W = 16;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

	// Configuration register indexes and reset values
	localparam logic REG_NUMERATOR = 1'b0;
	localparam logic REG_LIMIT     = 1'b1;

	localparam logic [31:0]        NUMERATOR_RST = 32'd280575540;
	localparam logic [SPEED_W-1:0] LIMIT_RST     = 16'd5500;

	// Input item kinds
	localparam logic FUNC_OVERFLOW = 1'b0;
	localparam logic FUNC_PULSE    = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] capture_count;
	} in_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] avg_speed;
		logic               updated;
		logic               limited;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PER,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_WR,
		ST_RD,
		ST_ACC,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_LIM,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic ovf_inc;
		logic cap;
		logic per;
		logic div_start;
		logic div_sel;   // 0: numerator / period, 1: sum / count
		logic ring_wr;
		logic rd;
		logic acc;
		logic avg_load;
		logic lim;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic upd;
		logic div_done;
		logic sum_last;
	} status_t;

endpackage

// ===== rtl/core/wheel_pulse_speed_averager_unit.sv =====
// Top level of the wheel pulse speed averager: register port, sequencer, datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | input     | in_valid/in_stall   | in_item: func, capture_count
//  out     | output    | out_valid/out_stall | out_item: avg_speed, updated, limited
//  cfg     | input     | psel/penable/pready | paddr, pwdata, prdata
//
// An overflow tick is counted without leaving idle; a later tick may follow in the next cycle.
// A pulse with a period from an earlier pulse passes twice through the shared 32-step divider
// and reads and adds up each ring entry in turn, the ring holding up to WINDOW entries.
// The first pulse after reset skips both divisions and the ring. Reset clears all control state;
// no clearing pass. A stalled result waits in the output register while the next
// item is accepted; the pulse after it then waits to load until that result is taken.
module wheel_pulse_speed_averager_unit #(
	parameter int WINDOW     = 10,
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  wpsa_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output wpsa_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import wpsa_pkg::*;

	logic [31:0]        numerator_q;
	logic [SPEED_W-1:0] limit_q;
	logic               reg_wr;
	logic               reg_sel;
	cmd_t               cmd;
	status_t            status;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= NUMERATOR_RST;
			limit_q     <= LIMIT_RST;
		end else if (reg_wr) begin
			unique case (reg_sel)
				REG_NUMERATOR: numerator_q <= pwdata;
				REG_LIMIT:     limit_q     <= pwdata[SPEED_W-1:0];
				default:       numerator_q <= numerator_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_sel)
			REG_NUMERATOR: prdata = numerator_q;
			REG_LIMIT:     prdata = 32'(limit_q);
			default:       prdata = '0;
		endcase
	end

	wpsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_item.func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	wpsa_datapath #(
		.WINDOW     (WINDOW),
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_item         (in_item),
		.speed_numerator (numerator_q),
		.speed_limit     (limit_q),
		.out_item        (out_item)
	);

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("result register overwritten while stalled");

	// A sample enters the ring only when an earlier pulse gave a period
	a_sample_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_wr |-> status.upd)
		else $error("ring written on first pulse");

	// A limited result always reports zero speed
	a_limited_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.limited) |-> (out_item.avg_speed == '0))
		else $error("limited result with nonzero speed");

	// Pulses are only taken while idle, so no overflow count during a pulse
	a_ovf_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ovf_inc |-> !in_stall)
		else $error("overflow counted while busy");

endmodule

// ===== rtl/core/wpsa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module wpsa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wpsa_pkg::DIV_W-1:0] dividend,
	input  logic [wpsa_pkg::DIV_W-1:0] divisor,
	output logic [wpsa_pkg::DIV_W-1:0] quotient,
	output logic                      done
);
	import wpsa_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, dsr_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/wpsa_datapath.sv =====
// Timestamp, period, speed ring, running sum, limit check and result register.
module wpsa_datapath #(
	parameter int WINDOW     = 10,
	parameter int TIMER_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wpsa_pkg::cmd_t               cmd,
	output wpsa_pkg::status_t            status,
	input  wpsa_pkg::in_item_t           in_item,
	input  logic [31:0]                  speed_numerator,
	input  logic [wpsa_pkg::SPEED_W-1:0] speed_limit,
	output wpsa_pkg::out_item_t          out_item
);
	import wpsa_pkg::*;

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SPEED_W + CNT_W;

	logic [31:0]        ovf_q;
	logic [TS_W-1:0]    ts_q;
	logic [TS_W-1:0]    prev_ts_q;
	logic [TS_W-1:0]    period_q;
	logic               seen_q;
	logic               upd_q;
	logic               lim_q;
	logic [IDX_W-1:0]   idx_q;
	logic               full_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SPEED_W-1:0] rd_data_q;
	logic [SPEED_W-1:0] held_q;
	out_item_t          out_q;

	logic [SPEED_W-1:0] ring_mem [WINDOW];

	logic [63:0]        ovf_shift;
	logic [63:0]        cap_masked;
	logic [TS_W-1:0]    ts_new;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIV_W-1:0]   div_divisor;
	logic [DIV_W-1:0]   div_quo;
	logic               div_done;
	logic [SPEED_W-1:0] speed;
	logic [CNT_W-1:0]   idx_inc;
	logic               idx_wrap;

	// Timestamp: overflow count above the timer bits, capture below
	assign ovf_shift  = 64'(ovf_q) << TIMER_BITS;
	assign cap_masked = 64'(in_item.capture_count) & ((64'd1 << TIMER_BITS) - 64'd1);
	assign ts_new     = ovf_shift[TS_W-1:0] | cap_masked[TS_W-1:0];

	// Shared divider operands
	always_comb begin
		if (cmd.div_sel) begin
			div_dividend = DIV_W'(sum_q);
			div_divisor  = DIV_W'(cnt_q);
		end else begin
			div_dividend = speed_numerator;
			div_divisor  = period_q[DIV_W-1:0];
		end
	end

	wpsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Speed: zero period saturates, a period past 32 bits gives zero, a quotient past 16 bits saturates
	always_comb begin
		if (period_q == '0) begin
			speed = SPEED_MAX;
		end else if (period_q[TS_W-1:DIV_W] != '0) begin
			speed = '0;
		end else if (div_quo[DIV_W-1:SPEED_W] != '0) begin
			speed = SPEED_MAX;
		end else begin
			speed = div_quo[SPEED_W-1:0];
		end
	end

	assign idx_inc  = CNT_W'(idx_q) + 1'b1;
	assign idx_wrap = (idx_inc == CNT_W'(WINDOW));

	// Control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q     <= '0;
			prev_ts_q <= '0;
			seen_q    <= 1'b0;
			idx_q     <= '0;
			full_q    <= 1'b0;
			held_q    <= '0;
		end else begin
			if (cmd.ovf_inc) begin
				ovf_q <= ovf_q + 1'b1;
			end
			if (cmd.per) begin
				prev_ts_q <= ts_q;
				seen_q    <= 1'b1;
			end
			if (cmd.ring_wr) begin
				idx_q <= idx_wrap ? '0 : idx_inc[IDX_W-1:0];
				if (idx_wrap) begin
					full_q <= 1'b1;
				end
			end
			if (cmd.avg_load) begin
				held_q <= div_quo[SPEED_W-1:0];
			end else if (cmd.lim && (held_q > speed_limit)) begin
				held_q <= '0;
			end
		end
	end

	// Per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ts_q  <= ts_new;
			upd_q <= seen_q;
			lim_q <= 1'b0;
		end
		if (cmd.per) begin
			period_q <= ts_q - prev_ts_q;
		end
		if (cmd.ring_wr) begin
			cnt_q <= (full_q || idx_wrap) ? CNT_W'(WINDOW) : idx_inc;
			ptr_q <= '0;
			sum_q <= '0;
		end
		if (cmd.rd) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.acc) begin
			sum_q <= sum_q + SUM_W'(rd_data_q);
		end
		if (cmd.lim && (held_q > speed_limit)) begin
			lim_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_q.avg_speed <= held_q;
			out_q.updated   <= upd_q;
			out_q.limited   <= lim_q;
		end
	end

	// Speed ring: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.ring_wr) begin
			ring_mem[idx_q] <= speed;
		end
		if (cmd.rd) begin
			rd_data_q <= ring_mem[ptr_q[IDX_W-1:0]];
		end
	end

	assign status.upd      = upd_q;
	assign status.div_done = div_done;
	assign status.sum_last = (ptr_q == cnt_q);
	assign out_item        = out_q;

endmodule

// ===== rtl/core/wpsa_ctrl.sv =====
// Sequencer for one pulse: period, speed division, ring sum, average division, limit, result load.
module wpsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_func,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  wpsa_pkg::status_t   status,
	output wpsa_pkg::cmd_t      cmd
);
	import wpsa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_func == FUNC_PULSE) begin
						cmd.cap = 1'b1;
						state_d = ST_PER;
					end else begin
						cmd.ovf_inc = 1'b1;
					end
				end
			end
			ST_PER: begin
				cmd.per = 1'b1;
				state_d = status.upd ? ST_DIV1_GO : ST_LIM;
			end
			ST_DIV1_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV1_WAIT;
			end
			ST_DIV1_WAIT: begin
				if (status.div_done) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				cmd.ring_wr = 1'b1;
				state_d     = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.sum_last ? ST_DIV2_GO : ST_RD;
			end
			ST_DIV2_GO: begin
				cmd.div_sel   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV2_WAIT;
			end
			ST_DIV2_WAIT: begin
				cmd.div_sel = 1'b1;
				if (status.div_done) begin
					cmd.avg_load = 1'b1;
					state_d      = ST_LIM;
				end
			end
			ST_LIM: begin
				cmd.lim = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result valid: set on load, cleared when the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
